// ===== src/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the tick task scheduler
// Command codes, register indexes, reset values and the result record
// passed from the scheduler core to the output stage.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Channel count and field widths
  localparam int NCH           = 3;
  localparam int DIV_WIDTH     = 16;
  localparam int HOOK_WIDTH    = 3;
  localparam int CNT_WIDTH     = 32;
  localparam int IDX_WIDTH     = 4;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int PENDING_WIDTH = 16;

  // Channel numbers
  localparam int CH_FAST = 0;
  localparam int CH_BUS  = 1;
  localparam int CH_LOG  = 2;

  // Divider reset values, fast in the lowest slot
  localparam logic [NCH-1:0][DIV_WIDTH-1:0] DIV_RESET = {16'd2000, 16'd10, 16'd5};

  // Commands
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SERVICE  = 2'd1,
    CMD_LOG_DONE = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_FAST_DIV = 2'd0,
    REG_BUS_DIV  = 2'd1,
    REG_LOG_DIV  = 2'd2,
    REG_HOOK_EN  = 2'd3
  } cfg_idx_t;

  // Counter read selectors
  localparam logic [IDX_WIDTH-1:0] SEL_RUN_FAST  = 4'd0;
  localparam logic [IDX_WIDTH-1:0] SEL_RUN_BUS   = 4'd1;
  localparam logic [IDX_WIDTH-1:0] SEL_RUN_LOG   = 4'd2;
  localparam logic [IDX_WIDTH-1:0] SEL_OVR_FAST  = 4'd3;
  localparam logic [IDX_WIDTH-1:0] SEL_OVR_BUS   = 4'd4;
  localparam logic [IDX_WIDTH-1:0] SEL_OVR_LOG   = 4'd5;
  localparam logic [IDX_WIDTH-1:0] SEL_PEND_FAST = 4'd6;
  localparam logic [IDX_WIDTH-1:0] SEL_PEND_BUS  = 4'd7;
  localparam logic [IDX_WIDTH-1:0] SEL_PEND_LOG  = 4'd8;

  // One result item
  typedef struct packed {
    logic [CNT_WIDTH-1:0] counter_value;
    logic                 ticks_dropped;
    logic [NCH-1:0]       run;           // bit0 fast, bit1 bus, bit2 log
  } result_t;

endpackage

// ===== src/tts_core.sv =====
// ----------------------------------------------------------------------------
// tts_core: scheduler state and per-item update
// Holds dividers, countdowns, pending, overrun and run counters and the
// drop flag; computes the result of the item held in the input register.
// ----------------------------------------------------------------------------
module tts_core #(
  parameter int PENDING_WIDTH = tts_pkg::PENDING_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tts_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [tts_pkg::DIV_WIDTH-1:0]       cfg_data,
  input  logic                                fire,
  input  tts_pkg::cmd_t                       command,
  input  logic [tts_pkg::IDX_WIDTH-1:0]       counter_index,
  output tts_pkg::result_t                    result
);

  localparam int NCH = tts_pkg::NCH;

  logic [tts_pkg::DIV_WIDTH-1:0]  divider   [NCH];
  logic [tts_pkg::HOOK_WIDTH-1:0] hook_enable;
  logic [tts_pkg::DIV_WIDTH-1:0]  countdown [NCH];
  logic [PENDING_WIDTH-1:0]       pending   [NCH];
  logic [tts_pkg::CNT_WIDTH-1:0]  overrun   [NCH];
  logic [tts_pkg::CNT_WIDTH-1:0]  run_cnt   [NCH];
  logic                           drop_flag;

  logic           tick_do;
  logic [NCH-1:0] expire;
  logic [NCH-1:0] run;
  logic           drop_flag_next;
  logic [tts_pkg::CNT_WIDTH-1:0] value;

  // Per-channel decode
  always_comb begin
    tick_do = (command == tts_pkg::CMD_TICK) && !drop_flag;
    for (int i = 0; i < NCH; i++) begin
      expire[i] = (countdown[i] <= tts_pkg::DIV_WIDTH'(1));
      run[i]    = (command == tts_pkg::CMD_SERVICE) && (pending[i] != '0);
    end
  end

  // Drop flag: set when the log task is taken with its hook on
  always_comb begin
    drop_flag_next = drop_flag;
    unique case (command)
      tts_pkg::CMD_SERVICE:  drop_flag_next = drop_flag | (run[tts_pkg::CH_LOG] &
                                                          hook_enable[tts_pkg::CH_LOG]);
      tts_pkg::CMD_LOG_DONE: drop_flag_next = 1'b0;
      default:               drop_flag_next = drop_flag;
    endcase
  end

  // Counter read mux
  always_comb begin
    value = '0;
    if (command == tts_pkg::CMD_READ) begin
      case (counter_index)
        tts_pkg::SEL_RUN_FAST:  value = run_cnt[tts_pkg::CH_FAST];
        tts_pkg::SEL_RUN_BUS:   value = run_cnt[tts_pkg::CH_BUS];
        tts_pkg::SEL_RUN_LOG:   value = run_cnt[tts_pkg::CH_LOG];
        tts_pkg::SEL_OVR_FAST:  value = overrun[tts_pkg::CH_FAST];
        tts_pkg::SEL_OVR_BUS:   value = overrun[tts_pkg::CH_BUS];
        tts_pkg::SEL_OVR_LOG:   value = overrun[tts_pkg::CH_LOG];
        tts_pkg::SEL_PEND_FAST: value = tts_pkg::CNT_WIDTH'(pending[tts_pkg::CH_FAST]);
        tts_pkg::SEL_PEND_BUS:  value = tts_pkg::CNT_WIDTH'(pending[tts_pkg::CH_BUS]);
        tts_pkg::SEL_PEND_LOG:  value = tts_pkg::CNT_WIDTH'(pending[tts_pkg::CH_LOG]);
        default:                value = '0;
      endcase
    end
  end

  assign result.run           = run;
  assign result.ticks_dropped = drop_flag_next;
  assign result.counter_value = value;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        divider[i]   <= tts_pkg::DIV_RESET[i];
        countdown[i] <= tts_pkg::DIV_RESET[i];
        pending[i]   <= '0;
        overrun[i]   <= '0;
        run_cnt[i]   <= '0;
      end
      hook_enable <= '0;
      drop_flag   <= 1'b0;
    end else begin
      if (fire) begin
        for (int i = 0; i < NCH; i++) begin
          if (tick_do) begin
            if (expire[i]) begin
              countdown[i] <= divider[i];
              // a raise onto a nonzero count is an overrun; saturate at all ones
              if (pending[i] != '0) overrun[i] <= overrun[i] + 1'b1;
              if (!(&pending[i]))   pending[i] <= pending[i] + 1'b1;
            end else begin
              countdown[i] <= countdown[i] - 1'b1;
            end
          end
          if (run[i]) begin
            pending[i] <= '0;
            run_cnt[i] <= run_cnt[i] + 1'b1;
          end
        end
        drop_flag <= drop_flag_next;
      end
      // configuration writes must arrive only while idle; the block does not enforce this
      if (cfg_we) begin
        unique case (tts_pkg::cfg_idx_t'(cfg_index))
          tts_pkg::REG_FAST_DIV: begin
            divider[tts_pkg::CH_FAST]   <= cfg_data;
            countdown[tts_pkg::CH_FAST] <= cfg_data;
          end
          tts_pkg::REG_BUS_DIV: begin
            divider[tts_pkg::CH_BUS]    <= cfg_data;
            countdown[tts_pkg::CH_BUS]  <= cfg_data;
          end
          tts_pkg::REG_LOG_DIV: begin
            divider[tts_pkg::CH_LOG]    <= cfg_data;
            countdown[tts_pkg::CH_LOG]  <= cfg_data;
          end
          tts_pkg::REG_HOOK_EN: begin
            hook_enable <= cfg_data[tts_pkg::HOOK_WIDTH-1:0];
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/multirate_tick_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// multirate_tick_task_scheduler_unit: three-channel tick divider scheduler
// Input register, scheduler core and output register in one pass.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel: tuser carries the command (tick,
//   service, log done, read counter), tdata the counter index for reads.
//   Every command yields exactly one item on m_axis: run flags, the drop
//   flag after the command and the counter value (zero unless a read).
//   Path: an accepted item is captured in the input register, then
//   processed by the core into the output register and offered on m_axis
//   from there until it is taken.
//   Throughput: one item per cycle while m_axis does not stall; the core
//   updates the counter state once per item.
//   When m_axis stalls, the output register holds its item, the input
//   register keeps one more, and s_axis_tready drops until space frees.
//   Reset (rst, synchronous) clears the counters and the drop flag, loads
//   the dividers 5, 10 and 2000 and their countdowns, and clears hooks.
//   The configuration port takes a write at any edge with cfg_we high and
//   rst low; writing a divider also reloads that channel's countdown.
// ----------------------------------------------------------------------------
module multirate_tick_task_scheduler_unit #(
  parameter int PENDING_WIDTH = tts_pkg::PENDING_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [tts_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [tts_pkg::DIV_WIDTH-1:0]     cfg_data,
  // command items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [3:0] counter_index, [7:4] zero
  input  logic [1:0]                        s_axis_tuser,  // [1:0] command
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata   // [0] run_fast, [1] run_bus,
                                                           // [2] run_log, [3] ticks_dropped,
                                                           // [35:4] counter_value, [39:36] zero
);

  logic                               in_valid;
  tts_pkg::cmd_t                      in_cmd;
  logic [tts_pkg::IDX_WIDTH-1:0]      in_idx;
  logic                               out_valid;
  tts_pkg::result_t                   out_result;
  tts_pkg::result_t                   core_result;
  logic                               advance;
  logic                               s_fire;

  // handshake
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_fire || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_cmd <= tts_pkg::cmd_t'(s_axis_tuser);
      in_idx <= s_axis_tdata[tts_pkg::IDX_WIDTH-1:0];
    end
  end

  tts_core #(
    .PENDING_WIDTH (PENDING_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fire          (advance),
    .command       (in_cmd),
    .counter_index (in_idx),
    .result        (core_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_result.counter_value, out_result.ticks_dropped,
                          out_result.run};

endmodule
